// File: hw/rtl/stsf_pkg.sv
// Shared types and constants for the scanline triangle span filler.
// Used by stsf_div and scanline_triangle_span_filler; depends on nothing.
`default_nettype none

package stsf_pkg;

    // Fixed widths of the result word and configuration registers
    localparam int OUT_W      = 14;
    localparam int COLOUR_W   = 24;
    localparam int ORIGIN_W   = 11;
    localparam int OUT_DATA_W = 72;   // 3*OUT_W + COLOUR_W = 66, padded to bytes

    // Input selector carried on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] REG_ORIGIN_X = 1'b0;
    localparam logic [0:0] REG_ORIGIN_Y = 1'b1;

    // Span sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_CMP,
        S_DL_GO,
        S_DL_WAIT,
        S_DR_GO,
        S_DR_WAIT,
        S_EMIT
    } state_t;

    // Divider request and status
    typedef struct packed {
        logic start;
        logic floor_mode;   // 0: truncate toward zero, 1: floor
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/scanline_triangle_span_filler.sv
// Scanline triangle span filler: holds one y-sorted triangle, emits one span per fetch while one is loaded.
// Depends on stsf_pkg and stsf_div.
//
//  channel  | dir | handshake         | contents
//  ---------+-----+-------------------+-------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | op on s_tuser, vertices and colour on s_tdata
//  m_*      | out | m_tvalid/m_tready | span on m_tdata, empty on m_tuser, m_tlast
//  cfg_*    | in  | cfg_we            | origin_x / origin_y by cfg_addr
//
// A load word is sorted combinationally and stored in its accept cycle.
// A fetch word keeps s_tready low after its accept until its span is emitted, through six
// steps of the shared multiplier and then two passes of the bit-serial divider.
// A fetch with no triangle loaded is dropped in its accept cycle.
// The result register lets a new word in while a span waits on m_tready; a second
// span holds in its last step, with s_tready low, until the first one is taken.
// Reset clears the held triangle, origins and all control state.
`default_nettype none

module scanline_triangle_span_filler #(
    parameter  int COORD_BITS = 12,
    localparam int IN_DATA_W  = ((6 * COORD_BITS + 24 + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // ax_in, ay_in, bx_in, by_in, cx_in, cy_in, fill_colour
    input  wire logic [IN_DATA_W-1:0]               s_tdata,
    // op
    input  wire logic                               s_tuser,
    // master stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // row_y, span_start, span_end, span_colour, zero pad
    output logic [stsf_pkg::OUT_DATA_W-1:0]         m_tdata,
    // span_empty
    output logic                                    m_tuser,
    // span_last
    output logic                                    m_tlast,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [0:0]                         cfg_addr,
    input  wire logic [stsf_pkg::ORIGIN_W-1:0]      cfg_data
);

    localparam int CW = COORD_BITS;
    localparam int NW = 2 * CW + 1;
    localparam int MW = NW + CW + 1;
    localparam int SW = ((CW > stsf_pkg::OUT_W) ? CW : stsf_pkg::OUT_W) + 2;
    localparam int OW = stsf_pkg::OUT_W;
    localparam int PAD_W = stsf_pkg::OUT_DATA_W - 3 * OW - stsf_pkg::COLOUR_W;

    stsf_pkg::state_t state_reg, state_next;

    // Held triangle and configuration
    logic [stsf_pkg::ORIGIN_W-1:0]  origin_x_reg;
    logic [stsf_pkg::ORIGIN_W-1:0]  origin_y_reg;
    logic signed [CW-1:0]           sx_reg [3];
    logic signed [CW-1:0]           sy_reg [3];
    logic [CW-1:0]                  row_index_reg;
    logic [stsf_pkg::COLOUR_W-1:0]  colour_reg;
    logic                           active_reg;

    // Per-span working registers
    logic signed [CW:0]   tot_reg;
    logic signed [CW:0]   seg_reg;
    logic signed [CW:0]   k_reg;
    logic signed [CW-1:0] base_reg;
    logic signed [CW:0]   dx_reg;
    logic signed [CW:0]   dxa_reg;
    logic signed [MW-1:0] prod_reg;
    logic signed [MW-1:0] cross_reg;
    logic signed [NW-1:0] an_reg;
    logic signed [NW-1:0] bn_reg;
    logic signed [NW-1:0] ln_reg;
    logic signed [NW-1:0] rn_reg;
    logic [CW-1:0]        ld_reg;
    logic [CW-1:0]        rd_reg;
    logic signed [CW:0]   start_reg;
    logic signed [CW:0]   end_reg;

    // Output register
    logic                           m_tvalid_reg;
    logic [stsf_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;

    // Input unpack and sort network
    logic signed [CW-1:0]           in_x [3];
    logic signed [CW-1:0]           in_y [3];
    logic signed [CW-1:0]           st1_x [3];
    logic signed [CW-1:0]           st1_y [3];
    logic signed [CW-1:0]           st2_x [3];
    logic signed [CW-1:0]           st2_y [3];
    logic signed [CW-1:0]           st3_x [3];
    logic signed [CW-1:0]           st3_y [3];
    logic [stsf_pkg::COLOUR_W-1:0]  in_colour;
    logic                           in_go;

    // Row setup
    logic signed [CW:0]   i_s;
    logic signed [CW:0]   cur_tot;
    logic signed [CW:0]   h1;
    logic                 second;
    logic signed [CW:0]   seg_raw;

    // Shared multiplier
    logic signed [NW-1:0] mul_a;
    logic signed [CW:0]   mul_b;
    logic signed [MW-1:0] mul_p;

    // Divider link
    stsf_pkg::div_ctrl_t  div_ctrl;
    stsf_pkg::div_stat_t  div_stat;
    logic signed [NW-1:0] div_num;
    logic [CW-1:0]        div_den;
    logic signed [CW:0]   div_quo;

    // Result assembly
    logic                 emit_go;
    logic                 last_w;
    logic [SW-1:0]        row_sum;
    logic [SW-1:0]        start_sum;
    logic [SW-1:0]        end_sum;

    // Unpack the load word
    assign in_x[0]   = s_tdata[CW-1:0];
    assign in_y[0]   = s_tdata[2*CW-1:CW];
    assign in_x[1]   = s_tdata[3*CW-1:2*CW];
    assign in_y[1]   = s_tdata[4*CW-1:3*CW];
    assign in_x[2]   = s_tdata[5*CW-1:4*CW];
    assign in_y[2]   = s_tdata[6*CW-1:5*CW];
    assign in_colour = s_tdata[6*CW+stsf_pkg::COLOUR_W-1:6*CW];
    assign in_go     = s_tvalid && s_tready;

    // Compare-swaps (0,1), (0,2), (1,2); swap only on strictly greater
    always_comb
    begin
        st1_x = in_x;
        st1_y = in_y;
        if (in_y[0] > in_y[1])
        begin
            st1_x[0] = in_x[1]; st1_y[0] = in_y[1];
            st1_x[1] = in_x[0]; st1_y[1] = in_y[0];
        end
        st2_x = st1_x;
        st2_y = st1_y;
        if (st1_y[0] > st1_y[2])
        begin
            st2_x[0] = st1_x[2]; st2_y[0] = st1_y[2];
            st2_x[2] = st1_x[0]; st2_y[2] = st1_y[0];
        end
        st3_x = st2_x;
        st3_y = st2_y;
        if (st2_y[1] > st2_y[2])
        begin
            st3_x[1] = st2_x[2]; st3_y[1] = st2_y[2];
            st3_x[2] = st2_x[1]; st3_y[2] = st2_y[1];
        end
    end

    // Row setup terms from the held triangle
    assign i_s     = $signed({1'b0, row_index_reg});
    assign cur_tot = (CW + 1)'(sy_reg[2]) - (CW + 1)'(sy_reg[0]);
    assign h1      = (CW + 1)'(sy_reg[1]) - (CW + 1)'(sy_reg[0]);
    assign second  = (i_s > h1) || (h1 == '0);
    assign seg_raw = second ? ((CW + 1)'(sy_reg[2]) - (CW + 1)'(sy_reg[1])) : h1;

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            stsf_pkg::S_M0:
            begin
                mul_a = NW'(sx_reg[0]);
                mul_b = tot_reg;
            end
            stsf_pkg::S_M1:
            begin
                mul_a = NW'(dxa_reg);
                mul_b = i_s;
            end
            stsf_pkg::S_M2:
            begin
                mul_a = NW'(base_reg);
                mul_b = seg_reg;
            end
            stsf_pkg::S_M3:
            begin
                mul_a = NW'(dx_reg);
                mul_b = k_reg;
            end
            stsf_pkg::S_M4:
            begin
                mul_a = an_reg;
                mul_b = seg_reg;
            end
            stsf_pkg::S_M5:
            begin
                mul_a = bn_reg;
                mul_b = tot_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider requests: left edge truncated, right edge floored
    assign div_ctrl.start      = (state_reg == stsf_pkg::S_DL_GO) ||
                                 (state_reg == stsf_pkg::S_DR_GO);
    assign div_ctrl.floor_mode = (state_reg == stsf_pkg::S_DR_GO);
    assign div_num             = (state_reg == stsf_pkg::S_DR_GO) ? rn_reg : ln_reg;
    assign div_den             = (state_reg == stsf_pkg::S_DR_GO) ? rd_reg : ld_reg;

    stsf_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Span result terms
    assign emit_go   = !m_tvalid_reg || m_tready;
    assign last_w    = (i_s + 1'b1) == tot_reg;
    assign row_sum   = SW'(sy_reg[0]) + SW'(row_index_reg) + SW'(origin_y_reg);
    assign start_sum = SW'(start_reg) + SW'(origin_x_reg);
    assign end_sum   = SW'(end_reg) + SW'(origin_x_reg);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        s_tready   = (state_reg == stsf_pkg::S_IDLE);
        unique case (state_reg)
            stsf_pkg::S_IDLE:
                if (in_go && (s_tuser == stsf_pkg::OP_FETCH) && active_reg)
                    state_next = stsf_pkg::S_PREP;
            stsf_pkg::S_PREP:    state_next = stsf_pkg::S_M0;
            stsf_pkg::S_M0:      state_next = stsf_pkg::S_M1;
            stsf_pkg::S_M1:      state_next = stsf_pkg::S_M2;
            stsf_pkg::S_M2:      state_next = stsf_pkg::S_M3;
            stsf_pkg::S_M3:      state_next = stsf_pkg::S_M4;
            stsf_pkg::S_M4:      state_next = stsf_pkg::S_M5;
            stsf_pkg::S_M5:      state_next = stsf_pkg::S_CMP;
            stsf_pkg::S_CMP:     state_next = stsf_pkg::S_DL_GO;
            stsf_pkg::S_DL_GO:   state_next = stsf_pkg::S_DL_WAIT;
            stsf_pkg::S_DL_WAIT:
                if (div_stat.done)
                    state_next = stsf_pkg::S_DR_GO;
            stsf_pkg::S_DR_GO:   state_next = stsf_pkg::S_DR_WAIT;
            stsf_pkg::S_DR_WAIT:
                if (div_stat.done)
                    state_next = stsf_pkg::S_EMIT;
            stsf_pkg::S_EMIT:
                if (emit_go)
                    state_next = stsf_pkg::S_IDLE;
            default:             state_next = stsf_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= stsf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration, held triangle and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            sx_reg        <= '{default: '0};
            sy_reg        <= '{default: '0};
            row_index_reg <= '0;
            colour_reg    <= '0;
            active_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    stsf_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                    stsf_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                endcase
            end

            if (in_go && (s_tuser == stsf_pkg::OP_LOAD))
            begin
                sx_reg        <= st3_x;
                sy_reg        <= st3_y;
                colour_reg    <= in_colour;
                row_index_reg <= '0;
                active_reg    <= (st3_y[2] > st3_y[0]);
            end

            // A new span refills the register; otherwise a taken word clears it
            if ((state_reg == stsf_pkg::S_EMIT) && emit_go)
            begin
                m_tvalid_reg  <= 1'b1;
                row_index_reg <= row_index_reg + 1'b1;
                if (last_w)
                    active_reg <= 1'b0;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Span datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            stsf_pkg::S_PREP:
            begin
                tot_reg  <= cur_tot;
                seg_reg  <= (seg_raw > '0) ? seg_raw : (CW + 1)'(1);
                k_reg    <= second ? (i_s - h1) : i_s;
                base_reg <= second ? sx_reg[1] : sx_reg[0];
                dx_reg   <= second ? ((CW + 1)'(sx_reg[2]) - (CW + 1)'(sx_reg[1]))
                                   : ((CW + 1)'(sx_reg[1]) - (CW + 1)'(sx_reg[0]));
                dxa_reg  <= (CW + 1)'(sx_reg[2]) - (CW + 1)'(sx_reg[0]);
            end
            stsf_pkg::S_M0:
                prod_reg <= mul_p;
            stsf_pkg::S_M1:
            begin
                an_reg   <= prod_reg[NW-1:0];
                prod_reg <= mul_p;
            end
            stsf_pkg::S_M2:
            begin
                an_reg   <= an_reg + prod_reg[NW-1:0];
                prod_reg <= mul_p;
            end
            stsf_pkg::S_M3:
            begin
                bn_reg   <= prod_reg[NW-1:0];
                prod_reg <= mul_p;
            end
            stsf_pkg::S_M4:
            begin
                bn_reg   <= bn_reg + prod_reg[NW-1:0];
                prod_reg <= mul_p;
            end
            stsf_pkg::S_M5:
            begin
                cross_reg <= prod_reg;
                prod_reg  <= mul_p;
            end
            // an/tot versus bn/seg by cross products; the smaller is the left edge
            stsf_pkg::S_CMP:
            begin
                if (cross_reg > prod_reg)
                begin
                    ln_reg <= bn_reg;  ld_reg <= seg_reg[CW-1:0];
                    rn_reg <= an_reg;  rd_reg <= tot_reg[CW-1:0];
                end
                else
                begin
                    ln_reg <= an_reg;  ld_reg <= tot_reg[CW-1:0];
                    rn_reg <= bn_reg;  rd_reg <= seg_reg[CW-1:0];
                end
            end
            stsf_pkg::S_DL_WAIT:
                if (div_stat.done)
                    start_reg <= div_quo;
            stsf_pkg::S_DR_WAIT:
                if (div_stat.done)
                    end_reg <= div_quo;
            stsf_pkg::S_EMIT:
                if (emit_go)
                begin
                    m_tdata_reg <= {{PAD_W{1'b0}}, colour_reg, end_sum[OW-1:0],
                                    start_sum[OW-1:0], row_sum[OW-1:0]};
                    m_tuser_reg <= (start_reg > end_reg);
                    m_tlast_reg <= last_w;
                end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == stsf_pkg::S_DL_WAIT ||
                           state_reg == stsf_pkg::S_DR_WAIT))
        else $error("divider result arrived outside a wait state");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (i_s < cur_tot))
        else $error("row index beyond triangle height while active");

    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stsf_pkg::S_EMIT && emit_go && last_w) |=> !active_reg)
        else $error("final span did not retire the triangle");

    a_empty_fetch_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && s_tuser == stsf_pkg::OP_FETCH && !active_reg)
        |=> (state_reg == stsf_pkg::S_IDLE))
        else $error("fetch without triangle started a span");

endmodule

`default_nettype wire

// File: hw/rtl/stsf_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on stsf_pkg (div_ctrl_t, div_stat_t).
// The quotient magnitude must be below 2**COORD_BITS (true for edge positions).
`default_nettype none

module stsf_div #(
    parameter  int COORD_BITS = 12,
    localparam int NW         = 2 * COORD_BITS + 1,
    localparam int CNT_W      = $clog2(COORD_BITS)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire stsf_pkg::div_ctrl_t      ctrl,
    input  wire logic signed [NW-1:0]     num,
    input  wire logic [COORD_BITS-1:0]    den,
    output stsf_pkg::div_stat_t           stat,
    output logic signed [COORD_BITS:0]    quo
);

    localparam int CW = COORD_BITS;

    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CW-1:0]        rem_reg;
    logic [CW-1:0]        dvd_reg;
    logic [CW-1:0]        den_reg;
    logic [CW-1:0]        q_reg;
    logic                 neg_reg;
    logic                 floor_reg;
    logic signed [CW:0]   quo_reg;

    logic [NW-1:0]        num_abs;
    logic [CW:0]          shifted;
    logic [CW:0]          trial;
    logic                 ge;
    logic [CW-1:0]        rem_next;
    logic [CW:0]          mag_q;
    logic [CW:0]          adj;
    logic signed [CW:0]   res;

    // Magnitude of the dividend
    assign num_abs = num[NW-1] ? (~num + 1'b1) : num;

    // One restoring step
    assign shifted  = {rem_reg, dvd_reg[CW-1]};
    assign trial    = shifted - {1'b0, den_reg};
    assign ge       = (shifted >= {1'b0, den_reg});
    assign rem_next = ge ? trial[CW-1:0] : shifted[CW-1:0];

    // Sign and rounding fixup
    assign mag_q = {1'b0, q_reg};
    assign adj   = {{CW{1'b0}}, (floor_reg && (rem_reg != '0))};
    assign res   = neg_reg ? $signed(~mag_q + 1'b1 - adj) : $signed(mag_q);

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && (cnt_reg == '0);
            if (ctrl.start)
                busy_reg <= 1'b1;
            else if (busy_reg && (cnt_reg == '0))
                busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg   <= num_abs[2*CW-1:CW];
            dvd_reg   <= num_abs[CW-1:0];
            den_reg   <= den;
            neg_reg   <= num[NW-1];
            floor_reg <= ctrl.floor_mode;
            cnt_reg   <= CNT_W'(CW - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[CW-2:0], 1'b0};
            q_reg   <= {q_reg[CW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (fin_reg)
            quo_reg <= res;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire
